>>> rtl/core/cb40_pkg.sv
package cb40_pkg;

    // Field widths of the channels.
    localparam int CHUNK_W  = 16;
    localparam int CHAR_W   = 7;
    localparam int COUNT_W  = 2;

    // Callsign limits.
    localparam int MAX_CHARS  = 9;
    localparam int NUM_CHUNKS = 3;

    // Valid range of a nonzero chunk.
    localparam logic [CHUNK_W-1:0] CHUNK_MIN = 16'h0640;
    localparam logic [CHUNK_W-1:0] CHUNK_MAX = 16'hF9FF;

    // Base-40 digit arithmetic.
    localparam int SYM_W     = 6;
    localparam int REM1_W    = 11;
    localparam int NUM_SLOTS = 3;
    localparam logic [CHUNK_W-1:0] WEIGHT_HI  = 16'd1600;
    localparam logic [REM1_W-1:0]  WEIGHT_MID = 11'd40;

    // value / 1600 == (value >> 6) / 25, and x / 25 == (x * 5243) >> 17 for x < 1024.
    localparam int          DIV25_SHIFT = 17;
    localparam logic [12:0] DIV25_MUL   = 13'd5243;
    // y / 5 == (y * 205) >> 10 for y < 256.
    localparam int          DIV5_SHIFT  = 10;
    localparam logic [7:0]  DIV5_MUL    = 8'd205;

    // Symbol codes.
    localparam logic [SYM_W-1:0] SYM_EMPTY     = 6'd0;
    localparam logic [SYM_W-1:0] SYM_LETTER_LO = 6'd1;
    localparam logic [SYM_W-1:0] SYM_LETTER_HI = 6'd26;
    localparam logic [SYM_W-1:0] SYM_DIGIT_LO  = 6'd27;
    localparam logic [SYM_W-1:0] SYM_DIGIT_HI  = 6'd36;
    localparam logic [SYM_W-1:0] SYM_SLASH     = 6'd37;
    localparam logic [SYM_W-1:0] SYM_DASH      = 6'd38;
    localparam logic [SYM_W-1:0] SYM_CARET     = 6'd39;

    // Running state widths.
    localparam int LEN_W = 5;
    localparam logic [LEN_W-1:0] LEN_SAT = 5'd31;
    localparam int IDX_W = $clog2(NUM_CHUNKS + 1);

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified chunk, as it travels from front to back.
    typedef struct packed {
        logic [SYM_W-1:0]  sym0;
        logic [SYM_W-1:0]  sym1;
        logic [REM1_W-1:0] rem1;
        logic              is_zero;
        logic              bad_range;
        logic              final_chunk;
    } cb40_entry_t;

    function automatic logic [CHAR_W-1:0] symbol_to_ascii(input logic [SYM_W-1:0] sym);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        if (sym >= SYM_LETTER_LO && sym <= SYM_LETTER_HI) begin
            ch = 7'(sym) + 7'd64;
        end
        else if (sym >= SYM_DIGIT_LO && sym <= SYM_DIGIT_HI) begin
            ch = 7'(sym) + 7'd21;
        end
        else if (sym == SYM_SLASH) begin
            ch = 7'h2F;
        end
        else if (sym == SYM_DASH) begin
            ch = 7'h2D;
        end
        else if (sym == SYM_CARET) begin
            ch = 7'h5E;
        end
        return ch;
    endfunction

endpackage

>>> rtl/core/cb40_ifs.sv
interface cb40_chunk_if;
    import cb40_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHUNK_W-1:0] chunk_value;
    logic               final_chunk;

    modport source (output valid, output chunk_value, output final_chunk, input ready);
    modport sink   (input valid, input chunk_value, input final_chunk, output ready);
endinterface

interface cb40_result_if;
    import cb40_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  char_first;
    logic [CHAR_W-1:0]  char_second;
    logic [CHAR_W-1:0]  char_third;
    logic [COUNT_W-1:0] char_count;
    logic               verdict_ready;
    logic               callsign_ok;

    modport source (output valid, output char_first, output char_second, output char_third,
                    output char_count, output verdict_ready, output callsign_ok, input ready);
    modport sink   (input valid, input char_first, input char_second, input char_third,
                    input char_count, input verdict_ready, input callsign_ok, output ready);
endinterface

>>> rtl/core/cb40_front.sv
module cb40_front (
    input  logic                 clk,
    input  logic                 rst_n,
    cb40_chunk_if.sink           chunk,
    output logic                 push_valid,
    output cb40_pkg::cb40_entry_t push_entry,
    input  logic                 push_ready
);
    import cb40_pkg::*;

    // Stage one: range classification and the top digit.
    logic               s1_valid_reg;
    logic [CHUNK_W-1:0] s1_value_reg;
    logic               s1_final_reg;
    logic [SYM_W-1:0]   s1_q1_reg;
    logic               s1_zero_reg;
    logic               s1_bad_reg;

    // Stage two: the middle digit and the remainder below the top digit.
    logic        s2_valid_reg;
    cb40_entry_t s2_entry_reg;

    logic              s1_move;
    logic              s2_move;
    logic [22:0]       q1_prod;
    logic              in_zero;
    logic [CHUNK_W-1:0] rem_hi;
    logic [7:0]        mid_in;
    logic [15:0]       q2_prod;
    cb40_entry_t       s2_entry_next;

    assign s2_move     = !s2_valid_reg || push_ready;
    assign s1_move     = !s1_valid_reg || s2_move;
    assign chunk.ready = s1_move;

    assign q1_prod = 23'(chunk.chunk_value[CHUNK_W-1:6]) * 23'(DIV25_MUL);
    assign in_zero = (chunk.chunk_value == '0);

    assign rem_hi  = s1_value_reg - 16'(s1_q1_reg) * WEIGHT_HI;
    assign mid_in  = rem_hi[REM1_W-1:3];
    assign q2_prod = 16'(mid_in) * 16'(DIV5_MUL);

    always_comb
    begin
        s2_entry_next.sym0        = s1_q1_reg;
        s2_entry_next.sym1        = q2_prod[DIV5_SHIFT+SYM_W-1:DIV5_SHIFT];
        s2_entry_next.rem1        = rem_hi[REM1_W-1:0];
        s2_entry_next.is_zero     = s1_zero_reg;
        s2_entry_next.bad_range   = s1_bad_reg;
        s2_entry_next.final_chunk = s1_final_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else begin
            if (s1_move) begin
                s1_valid_reg <= chunk.valid;
            end
            if (s2_move) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && chunk.valid) begin
            s1_value_reg <= chunk.chunk_value;
            s1_final_reg <= chunk.final_chunk;
            s1_q1_reg    <= q1_prod[DIV25_SHIFT+SYM_W-1:DIV25_SHIFT];
            s1_zero_reg  <= in_zero;
            s1_bad_reg   <= !in_zero && (chunk.chunk_value < CHUNK_MIN ||
                                         chunk.chunk_value > CHUNK_MAX);
        end
        if (s2_move && s1_valid_reg) begin
            s2_entry_reg <= s2_entry_next;
        end
    end

    assign push_valid = s2_valid_reg;
    assign push_entry = s2_entry_reg;

endmodule

>>> rtl/core/cb40_queue.sv
module cb40_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  cb40_pkg::cb40_entry_t push_entry,
    output logic                  push_ready,
    output logic                  pop_valid,
    output cb40_pkg::cb40_entry_t pop_entry,
    input  logic                  pop_ready
);
    import cb40_pkg::*;

    cb40_entry_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/cb40_back.sv
module cb40_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    input  cb40_pkg::cb40_entry_t pop_entry,
    output logic                  pop_ready,
    cb40_result_if.source         result
);
    import cb40_pkg::*;

    // Callsign state.
    logic             at_first_reg;
    logic             saw_empty_reg;
    logic             has_failed_reg;
    logic [LEN_W-1:0] length_reg;
    logic [IDX_W-1:0] index_reg;

    logic             at_first_next;
    logic             saw_empty_next;
    logic             has_failed_next;
    logic [LEN_W-1:0] length_next;
    logic [IDX_W-1:0] index_next;

    // Output register.
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg [NUM_SLOTS];
    logic [COUNT_W-1:0] count_reg;
    logic               verdict_reg;
    logic               ok_reg;

    logic [CHAR_W-1:0]  char_next [NUM_SLOTS];
    logic [COUNT_W-1:0] count_next;
    logic               ok_next;

    logic [REM1_W-1:0] rem2;
    logic [SYM_W-1:0]  sym [NUM_SLOTS];
    logic              take;

    assign pop_ready = !out_valid_reg || result.ready;
    assign take      = pop_valid && pop_ready;

    assign rem2   = pop_entry.rem1 - 11'(pop_entry.sym1) * WEIGHT_MID;
    assign sym[0] = pop_entry.sym0;
    assign sym[1] = pop_entry.sym1;
    assign sym[2] = rem2[SYM_W-1:0];

    always_comb
    begin
        saw_empty_next  = saw_empty_reg;
        has_failed_next = has_failed_reg;
        length_next     = length_reg;
        index_next      = index_reg;
        count_next      = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            char_next[k] = '0;
        end

        if (index_reg >= IDX_W'(NUM_CHUNKS)) begin
            has_failed_next = 1'b1;
        end
        else begin
            index_next = index_reg + 1'b1;
        end

        if (pop_entry.is_zero) begin
            if (at_first_reg) begin
                has_failed_next = 1'b1;
            end
            saw_empty_next = 1'b1;
        end
        else if (pop_entry.bad_range) begin
            has_failed_next = 1'b1;
        end
        else begin
            // Slots are taken in order; a character after a gap poisons the callsign.
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (sym[k] == SYM_EMPTY) begin
                    saw_empty_next = 1'b1;
                end
                else begin
                    if (saw_empty_next) begin
                        has_failed_next = 1'b1;
                    end
                    char_next[k] = symbol_to_ascii(sym[k]);
                    count_next   = count_next + 1'b1;
                    if (length_next != LEN_SAT) begin
                        length_next = length_next + 1'b1;
                    end
                    if (length_next > LEN_W'(MAX_CHARS)) begin
                        has_failed_next = 1'b1;
                    end
                end
            end
        end

        at_first_next = 1'b0;
        ok_next = pop_entry.final_chunk && !has_failed_next && (length_next != '0);

        if (pop_entry.final_chunk) begin
            at_first_next   = 1'b1;
            saw_empty_next  = 1'b0;
            has_failed_next = 1'b0;
            length_next     = '0;
            index_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            at_first_reg   <= 1'b1;
            saw_empty_reg  <= 1'b0;
            has_failed_reg <= 1'b0;
            length_reg     <= '0;
            index_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            if (take) begin
                at_first_reg   <= at_first_next;
                saw_empty_reg  <= saw_empty_next;
                has_failed_reg <= has_failed_next;
                length_reg     <= length_next;
                index_reg      <= index_next;
            end
            if (pop_ready) begin
                out_valid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                char_reg[k] <= char_next[k];
            end
            count_reg   <= count_next;
            verdict_reg <= pop_entry.final_chunk;
            ok_reg      <= ok_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.char_first    = char_reg[0];
    assign result.char_second   = char_reg[1];
    assign result.char_third    = char_reg[2];
    assign result.char_count    = count_reg;
    assign result.verdict_ready = verdict_reg;
    assign result.callsign_ok   = ok_reg;

    // A final beat always leaves the state as after reset.
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && pop_entry.final_chunk |=> at_first_reg && length_reg == '0 &&
                                          !has_failed_reg && !saw_empty_reg)
        else $error("state not cleared after final chunk");

    // An accepted verdict of ok only comes with the verdict flag.
    a_ok_needs_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ok_reg |-> verdict_reg)
        else $error("callsign_ok without verdict_ready");

    // The count agrees with the nonzero character slots.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> 32'($countones({char_reg[0] != '0, char_reg[1] != '0,
                                            char_reg[2] != '0})) == 32'(count_reg))
        else $error("char_count disagrees with characters");

endmodule

>>> rtl/core/callsign_base40_decoder.sv
// Base-40 callsign decoder. Each input beat carries one 16-bit chunk holding three
// base-40 symbols (first symbol weighted by 1600, second by 40) and a flag marking
// the last chunk of a callsign. Every beat produces exactly one result beat with the
// three decoded ASCII characters in slot order (0 for an empty slot) and their count;
// the result for the last chunk also carries the verdict for the whole callsign, after
// which the decoder starts afresh. A zero first chunk, a nonzero chunk outside
// 1600..63999, a character following an empty slot, more than nine characters, more
// than three chunks, or a callsign with no characters all make the verdict not ok.
// Throughput is one chunk per clock while result ready stays high. A result is valid
// once its chunk has passed these registers in order: the first and then the second
// of two front stages that split the chunk into digits by reciprocal multiplication,
// the two-entry queue, and the output register, which the back end loads as it updates
// the callsign state. The queue lets the front keep taking chunks while a finished
// result waits on the output; input ready drops only once the queue and both front
// stages are full.
module callsign_base40_decoder (
    input  logic          clk,
    input  logic          rst_n,
    cb40_chunk_if.sink    chunk,
    cb40_result_if.source result
);
    import cb40_pkg::*;

    logic        push_valid;
    logic        push_ready;
    cb40_entry_t push_entry;
    logic        pop_valid;
    logic        pop_ready;
    cb40_entry_t pop_entry;

    // Front end: digit extraction and range classification, no callsign state.
    cb40_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chunk      (chunk),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    // Short queue so the front and back stall independently.
    cb40_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop_ready  (pop_ready)
    );

    // Back end: per-callsign flags, character mapping and the output register.
    cb40_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_entry (pop_entry),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule
